[rtl/core/audio_format_sniffer_assert.svh]
// ----------------------------------------------------------------------------
// audio_format_sniffer_assert.svh
// Assertion macros shared by the sniffer RTL. Clock clk_i, reset rst_ni.
// ----------------------------------------------------------------------------
`ifndef AUDIO_FORMAT_SNIFFER_ASSERT_SVH
`define AUDIO_FORMAT_SNIFFER_ASSERT_SVH

// Checked out of reset only.
`define AFS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define AFS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/afs_pkg.sv]
// ----------------------------------------------------------------------------
// afs_pkg
// Types, constants and helpers for the audio format sniffer.
// ----------------------------------------------------------------------------
package afs_pkg;

  localparam int HeaderLen = 44;
  localparam int CntW      = $clog2(HeaderLen + 1);

  typedef logic [CntW-1:0] cnt_t;

  // byte positions and length thresholds
  localparam cnt_t MinLen     = CntW'(4);
  localparam cnt_t WavePos    = CntW'(8);
  localparam cnt_t WaveMinLen = CntW'(12);
  localparam cnt_t TagLowPos  = CntW'(20);
  localparam cnt_t TagHighPos = CntW'(21);
  localparam cnt_t TagMinLen  = CntW'(22);
  localparam cnt_t HeaderEnd  = CntW'(HeaderLen);

  // result codes
  localparam logic [2:0] FmtUnknown = 3'd0;
  localparam logic [2:0] FmtWavPcm  = 3'd1;
  localparam logic [2:0] FmtWavIma  = 3'd2;
  localparam logic [2:0] FmtOgg     = 3'd3;
  localparam logic [2:0] FmtMp3     = 3'd4;

  // match flag bits
  localparam int FlagRiff = 0;
  localparam int FlagWave = 1;
  localparam int FlagOgg  = 2;
  localparam int FlagId3  = 3;
  localparam logic [3:0] FlagsInit = 4'hF;

  localparam logic [15:0] TagPcm = 16'h0001;
  localparam logic [15:0] TagIma = 16'h0011;

  localparam logic [7:0] RiffMagic [4] = '{8'h52, 8'h49, 8'h46, 8'h46};
  localparam logic [7:0] WaveMagic [4] = '{8'h57, 8'h41, 8'h56, 8'h45};
  localparam logic [7:0] OggMagic  [4] = '{8'h4F, 8'h67, 8'h67, 8'h53};
  localparam logic [7:0] Id3Magic  [3] = '{8'h49, 8'h44, 8'h33};

  localparam logic [7:0] SyncByte = 8'hFF;
  localparam logic [2:0] SyncHigh = 3'b111;
  localparam logic [1:0] VersionReserved = 2'b01;
  localparam logic [1:0] LayerReserved   = 2'b00;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       last_byte;
  } afs_item_t;

  // frame sync: 11 set bits, version not reserved, layer not reserved
  function automatic logic is_mp3_sync(logic [7:0] first, logic [7:0] second);
    return (first == SyncByte) && (second[7:5] == SyncHigh) &&
           (second[4:3] != VersionReserved) && (second[2:1] != LayerReserved);
  endfunction

endpackage

[rtl/core/audio_format_sniffer.sv]
// ----------------------------------------------------------------------------
// audio_format_sniffer
// Names the audio format of a file from its first header bytes.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+----------------------------
//  in       | sink      | in_valid_i / in_stall_o | header_byte_i, last_byte_i
//  out      | source    | out_valid_o / out_stall_i | format_code_o
//
// One byte per cycle while the input is not stalled; a last byte passes the
// input register, then the result register, before its result is presented.
// Reset clears the header state; the first byte after reset is offset 0.
// A waiting result stalls input only when the held byte is a last byte;
// ordinary bytes keep flowing while the sink stalls.
// ----------------------------------------------------------------------------
`include "audio_format_sniffer_assert.svh"

module audio_format_sniffer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] header_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] format_code_o
);
  import afs_pkg::*;

  afs_item_t in_item;
  afs_item_t cur_item;
  logic      cur_valid;
  logic      take;
  logic      out_ready;
  logic [2:0] code;

  assign in_item.header_byte = header_byte_i;
  assign in_item.last_byte   = last_byte_i;

  // a last byte needs room in the result register
  assign take = cur_valid && (!cur_item.last_byte || out_ready);

  afs_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .valid_o    (cur_valid),
    .item_o     (cur_item),
    .take_i     (take)
  );

  afs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .take_i (take),
    .item_i (cur_item),
    .code_o (code)
  );

  afs_out_stage u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take && cur_item.last_byte),
    .code_i        (code),
    .ready_o       (out_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .format_code_o (format_code_o)
  );

  `AFS_ASSERT(a_stall_cause, in_stall_o |-> cur_valid && cur_item.last_byte && out_valid_o && out_stall_i, "input stalled without a blocked result")

endmodule

[rtl/core/afs_in_stage.sv]
// ----------------------------------------------------------------------------
// afs_in_stage
// Input register. Holds one byte until the sniffer core takes it.
// ----------------------------------------------------------------------------
`include "audio_format_sniffer_assert.svh"

module afs_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  afs_pkg::afs_item_t item_i,
  output logic              valid_o,
  output afs_pkg::afs_item_t item_o,
  input  logic              take_i
);
  import afs_pkg::*;

  logic      valid_q;
  afs_item_t item_q;
  logic      load;

  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

  `AFS_ASSERT(a_take_needs_item, take_i |-> valid_q, "core took from an empty input register")

endmodule

[rtl/core/afs_core.sv]
// ----------------------------------------------------------------------------
// afs_core
// Header state per file: byte count, magic match flags, format tag and
// frame sync flag. Gives the format code of the file on its last byte.
// ----------------------------------------------------------------------------
`include "audio_format_sniffer_assert.svh"

module afs_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               take_i,
  input  afs_pkg::afs_item_t item_i,
  output logic [2:0]         code_o
);
  import afs_pkg::*;

  cnt_t       cnt_q, cnt_d;
  logic [7:0] prev_q, prev_d;
  logic [3:0] flags_q, flags_d;
  logic [7:0] tag_lo_q, tag_lo_d;
  logic [7:0] tag_hi_q, tag_hi_d;
  logic       sync_q, sync_d;

  // updated state, before the end-of-file clear
  cnt_t       cnt_u;
  logic [7:0] prev_u;
  logic [3:0] flags_u;
  logic [7:0] tag_lo_u;
  logic [7:0] tag_hi_u;
  logic       sync_u;
  logic [7:0] b;
  logic [1:0] idx;

  assign b   = item_i.header_byte;
  assign idx = cnt_q[1:0];

  always_comb begin
    cnt_u    = cnt_q;
    prev_u   = prev_q;
    flags_u  = flags_q;
    tag_lo_u = tag_lo_q;
    tag_hi_u = tag_hi_q;
    sync_u   = sync_q;
    if (cnt_q < HeaderEnd) begin
      if (cnt_q < MinLen) begin
        if (b != RiffMagic[idx]) flags_u[FlagRiff] = 1'b0;
        if (b != OggMagic[idx])  flags_u[FlagOgg]  = 1'b0;
        if (idx != 2'd3 && b != Id3Magic[idx]) flags_u[FlagId3] = 1'b0;
      end
      // positions 8..11 share the low two bits with 0..3
      if (cnt_q >= WavePos && cnt_q < WaveMinLen && b != WaveMagic[idx]) begin
        flags_u[FlagWave] = 1'b0;
      end
      if (cnt_q == TagLowPos)  tag_lo_u = b;
      if (cnt_q == TagHighPos) tag_hi_u = b;
      if (cnt_q != '0 && is_mp3_sync(prev_q, b)) sync_u = 1'b1;
      prev_u = b;
      cnt_u  = cnt_q + cnt_t'(1);
    end
  end

  always_comb begin
    code_o = FmtUnknown;
    if (cnt_u < MinLen) begin
      code_o = FmtUnknown;
    end else if (cnt_u >= WaveMinLen && flags_u[FlagRiff] && flags_u[FlagWave]) begin
      if (cnt_u < TagMinLen) begin
        code_o = FmtWavPcm;
      end else if ({tag_hi_u, tag_lo_u} == TagPcm) begin
        code_o = FmtWavPcm;
      end else if ({tag_hi_u, tag_lo_u} == TagIma) begin
        code_o = FmtWavIma;
      end else begin
        code_o = FmtUnknown;
      end
    end else if (flags_u[FlagOgg]) begin
      code_o = FmtOgg;
    end else if (flags_u[FlagId3] || sync_u) begin
      code_o = FmtMp3;
    end
  end

  always_comb begin
    cnt_d    = cnt_q;
    prev_d   = prev_q;
    flags_d  = flags_q;
    tag_lo_d = tag_lo_q;
    tag_hi_d = tag_hi_q;
    sync_d   = sync_q;
    if (take_i) begin
      if (item_i.last_byte) begin
        cnt_d    = '0;
        prev_d   = '0;
        flags_d  = FlagsInit;
        tag_lo_d = '0;
        tag_hi_d = '0;
        sync_d   = 1'b0;
      end else begin
        cnt_d    = cnt_u;
        prev_d   = prev_u;
        flags_d  = flags_u;
        tag_lo_d = tag_lo_u;
        tag_hi_d = tag_hi_u;
        sync_d   = sync_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      prev_q   <= '0;
      flags_q  <= FlagsInit;
      tag_lo_q <= '0;
      tag_hi_q <= '0;
      sync_q   <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      prev_q   <= prev_d;
      flags_q  <= flags_d;
      tag_lo_q <= tag_lo_d;
      tag_hi_q <= tag_hi_d;
      sync_q   <= sync_d;
    end
  end

  `AFS_ASSERT(a_cnt_bound, cnt_q <= HeaderEnd, "byte count ran past the header length")
  `AFS_ASSERT(a_clear_after_last,
              take_i && item_i.last_byte |=> cnt_q == '0 && flags_q == FlagsInit && !sync_q,
              "state not cleared after last byte")
  `AFS_ASSERT(a_sync_needs_pair, sync_q |-> cnt_q >= CntW'(2), "sync flag set with fewer than two bytes")

endmodule

[rtl/core/afs_out_stage.sv]
// ----------------------------------------------------------------------------
// afs_out_stage
// Result register. Holds the format code until the sink takes it.
// ----------------------------------------------------------------------------
`include "audio_format_sniffer_assert.svh"

module afs_out_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  logic [2:0] code_i,
  output logic       ready_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] format_code_o
);
  import afs_pkg::*;

  logic       valid_q;
  logic [2:0] code_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      code_q <= code_i;
    end
  end

  assign out_valid_o   = valid_q;
  assign format_code_o = code_q;

  `AFS_ASSERT(a_load_when_free, load_i |-> ready_o, "result loaded over a waiting one")
  `AFS_ASSERT(a_code_range, valid_q |-> code_q <= FmtMp3, "format code out of range")

endmodule
